FILE: hdl/bankers_deadlock_avoidance_defines.svh
// assertion macros for the banker's allocator
`ifndef BANKERS_DEADLOCK_AVOIDANCE_DEFINES_SVH
`define BANKERS_DEADLOCK_AVOIDANCE_DEFINES_SVH

// same-cycle implication, off during reset
`define BDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bda assertion failed");

// next-cycle implication, off during reset
`define BDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bda assertion failed");

// next-cycle implication, always on
`define BDA_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bda assertion failed");

`endif

FILE: hdl/bda_pkg.sv
package bda_pkg;

    localparam logic [1:0] OP_TOTAL = 2'd0;
    localparam logic [1:0] OP_MAX   = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;
    localparam logic [1:0] OP_REQ   = 2'd3;

    localparam logic [2:0] ST_GRANT   = 3'd0;
    localparam logic [2:0] ST_EXNEED  = 3'd1;
    localparam logic [2:0] ST_EXAVAIL = 3'd2;
    localparam logic [2:0] ST_UNSAFE  = 3'd3;
    localparam logic [2:0] ST_BADPROC = 3'd4;

    localparam logic [1:0] WK_CHK    = 2'd0;
    localparam logic [1:0] WK_FIT    = 2'd1;
    localparam logic [1:0] WK_ADD    = 2'd2;
    localparam logic [1:0] WK_COMMIT = 2'd3;

    typedef struct packed {
        logic       accept;
        logic       load2;
        logic       walk_run;
        logic [1:0] walk_kind;
        logic       init_work;
        logic       mark_fin;
        logic       next_proc;
        logic       new_pass;
        logic       seq_start;
        logic       clear_req;
        logic       emit_seq;
        logic       emit_stat;
        logic [2:0] code;
        logic       clear_step;
    } t_cmd;

    typedef struct packed {
        logic item_op2;
        logic item_eval;
        logic item_bad;
        logic walk_done;
        logic ex_need;
        logic ex_avail;
        logic fits;
        logic fin_cur;
        logic last_proc;
        logic progress;
        logic all_done;
        logic clear_done;
        logic out_free;
        logic emit_last;
    } t_stat;

endpackage

FILE: hdl/bda_ctrl.sv
module bda_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output bda_pkg::t_cmd o_cmd,
    input  bda_pkg::t_stat i_st
);
    import bda_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LOAD2  = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_INIT   = 4'd4;
    localparam logic [3:0] S_PROC   = 4'd5;
    localparam logic [3:0] S_FIT    = 4'd6;
    localparam logic [3:0] S_ADD    = 4'd7;
    localparam logic [3:0] S_NEXT   = 4'd8;
    localparam logic [3:0] S_COMMIT = 4'd9;
    localparam logic [3:0] S_SEQ    = 4'd10;
    localparam logic [3:0] S_STAT   = 4'd11;

    logic [3:0] r_state, n_state;
    logic [2:0] r_code, n_code;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_code  = r_code;
        o_cmd.code = r_code;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_st.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.item_op2) begin
                        n_state = S_LOAD2;
                    end else if (i_st.item_eval) begin
                        if (i_st.item_bad) begin
                            n_code  = ST_BADPROC;
                            n_state = S_STAT;
                        end else begin
                            n_state = S_CHK;
                        end
                    end
                end
            end
            S_LOAD2: begin
                o_cmd.load2 = 1'b1;
                n_state = S_IDLE;
            end
            S_CHK: begin
                o_cmd.walk_run  = 1'b1;
                o_cmd.walk_kind = WK_CHK;
                if (i_st.walk_done) begin
                    if (i_st.ex_need) begin
                        n_code  = ST_EXNEED;
                        n_state = S_STAT;
                    end else if (i_st.ex_avail) begin
                        n_code  = ST_EXAVAIL;
                        n_state = S_STAT;
                    end else begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init_work = 1'b1;
                n_state = S_PROC;
            end
            S_PROC: begin
                n_state = i_st.fin_cur ? S_NEXT : S_FIT;
            end
            S_FIT: begin
                o_cmd.walk_run  = 1'b1;
                o_cmd.walk_kind = WK_FIT;
                if (i_st.walk_done) n_state = i_st.fits ? S_ADD : S_NEXT;
            end
            S_ADD: begin
                o_cmd.walk_run  = 1'b1;
                o_cmd.walk_kind = WK_ADD;
                if (i_st.walk_done) begin
                    o_cmd.mark_fin = 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (!i_st.last_proc) begin
                    o_cmd.next_proc = 1'b1;
                    n_state = S_PROC;
                end else if (i_st.progress && !i_st.all_done) begin
                    o_cmd.new_pass = 1'b1;
                    n_state = S_PROC;
                end else if (i_st.all_done) begin
                    n_state = S_COMMIT;
                end else begin
                    n_code  = ST_UNSAFE;
                    n_state = S_STAT;
                end
            end
            S_COMMIT: begin
                o_cmd.walk_run  = 1'b1;
                o_cmd.walk_kind = WK_COMMIT;
                if (i_st.walk_done) begin
                    o_cmd.seq_start = 1'b1;
                    o_cmd.clear_req = 1'b1;
                    n_state = S_SEQ;
                end
            end
            S_SEQ: begin
                if (i_st.out_free) begin
                    o_cmd.emit_seq = 1'b1;
                    if (i_st.emit_last) n_state = S_IDLE;
                end
            end
            S_STAT: begin
                if (i_st.out_free) begin
                    o_cmd.emit_stat = 1'b1;
                    o_cmd.clear_req = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= ST_GRANT;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

endmodule

FILE: hdl/bda_dp.sv
module bda_dp #(
    parameter int MAX_PROCS = 8,
    parameter int MAX_RES   = 16,
    parameter int UNIT_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bda_pkg::t_cmd                      i_cmd,
    output bda_pkg::t_stat                     o_st,
    input  logic [1:0]                         i_op,
    input  logic [2:0]                         i_process,
    input  logic [3:0]                         i_resource,
    input  logic [15:0]                        i_amount,
    input  logic                               i_last,
    input  logic [$clog2(MAX_PROCS+1)-1:0]     i_np,
    input  logic [$clog2(MAX_RES+1)-1:0]       i_nr,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic [2:0]                         o_status,
    output logic [2:0]                         o_safe_process,
    output logic                               o_final_res
);
    import bda_pkg::*;

    localparam int SW    = UNIT_BITS + 2;
    localparam int AL    = UNIT_BITS + 1;
    localparam int AMT_W = (UNIT_BITS < 16) ? UNIT_BITS : 16;
    localparam int DEPTH = MAX_PROCS * MAX_RES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int RW    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int PCW   = $clog2(MAX_PROCS + 1);
    localparam int CW    = $clog2(MAX_RES + 1);
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    function automatic logic signed [SW-1:0] f_sat(input logic signed [SW:0] s);
        if (s[SW] != s[SW-1]) f_sat = s[SW] ? SMIN : SMAX;
        else f_sat = s[SW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] f_sub(input logic signed [SW-1:0] a,
                                                   input logic [AMT_W-1:0] b);
        logic signed [SW:0] s;
        s = {a[SW-1], a} - {{(SW+1-AMT_W){1'b0}}, b};
        f_sub = f_sat(s);
    endfunction

    function automatic logic signed [SW-1:0] f_add(input logic signed [SW-1:0] a,
                                                   input logic [AL-1:0] b);
        logic signed [SW:0] s;
        s = {a[SW-1], a} + {2'b00, b};
        f_add = f_sat(s);
    endfunction

    function automatic logic [AL-1:0] f_aadd(input logic [AL-1:0] a,
                                             input logic [AMT_W-1:0] b);
        logic [AL:0] s;
        s = {1'b0, a} + (AL+1)'(b);
        f_aadd = s[AL] ? {AL{1'b1}} : s[AL-1:0];
    endfunction

    function automatic logic f_gt(input logic [AMT_W-1:0] a, input logic signed [SW-1:0] b);
        f_gt = $signed(SW'(a)) > b;
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [31:0] p, input logic [31:0] r);
        f_addr = AW'(p * MAX_RES + r);
    endfunction

    logic signed [SW-1:0] r_need_mem [DEPTH];
    logic [AL-1:0]        r_alloc_mem [DEPTH];
    logic signed [SW-1:0] r_need_rd;
    logic [AL-1:0]        r_alloc_rd;

    logic signed [SW-1:0] r_avail [MAX_RES];
    logic signed [SW-1:0] r_work [MAX_RES];
    logic [AMT_W-1:0]     r_req [MAX_RES];
    logic [MAX_PROCS-1:0] r_fin;
    logic [PW-1:0]        r_order [MAX_PROCS];

    logic [PW-1:0]    r_p, r_i, r_k;
    logic [PCW-1:0]   r_cnt;
    logic             r_progress;
    logic [AW-1:0]    r_ld_addr, r_clr;
    logic [AMT_W-1:0] r_ld_amt;
    logic             r_ld_ok;
    logic [CW-1:0]    r_j;
    logic [RW-1:0]    r_jd;
    logic             r_dv, r_ex_need, r_ex_avail, r_fits;
    logic             r_ov, r_of;
    logic [2:0]       r_os, r_osp;

    logic [AMT_W-1:0]     w_amt, w_reqd;
    logic                 w_p_ok, w_r_ok, w_issue, w_own, w_done;
    logic [RW-1:0]        w_ri, w_jr;
    logic [PW-1:0]        w_base;
    logic [AW-1:0]        w_item_addr, w_walk_addr, w_wb_addr, w_ra, w_wa;
    logic signed [SW-1:0] w_need_t, w_need_wd;
    logic [AL-1:0]        w_alloc_t, w_alloc_wd;
    logic                 w_f_need, w_f_avail, w_f_fit;
    logic                 w_need_we, w_alloc_we, w_commit, w_emit_last;

    assign w_amt       = i_amount[AMT_W-1:0];
    assign w_p_ok      = 32'(i_process) < 32'(MAX_PROCS);
    assign w_r_ok      = 32'(i_resource) < 32'(MAX_RES);
    assign w_ri        = RW'(i_resource);
    assign w_item_addr = f_addr(32'(i_process), 32'(i_resource));

    assign w_base      = (i_cmd.walk_kind == WK_FIT || i_cmd.walk_kind == WK_ADD) ? r_i : r_p;
    assign w_issue     = i_cmd.walk_run && (r_j < i_nr);
    assign w_jr        = r_j[RW-1:0];
    assign w_walk_addr = f_addr(32'(w_base), 32'(w_jr));
    assign w_wb_addr   = f_addr(32'(w_base), 32'(r_jd));
    assign w_ra        = i_cmd.walk_run ? w_walk_addr : w_item_addr;

    assign w_reqd    = r_req[r_jd];
    assign w_own     = (r_i == r_p);
    assign w_need_t  = w_own ? f_sub(r_need_rd, w_reqd) : r_need_rd;
    assign w_alloc_t = w_own ? f_aadd(r_alloc_rd, w_reqd) : r_alloc_rd;
    assign w_f_need  = r_dv && f_gt(w_reqd, r_need_rd);
    assign w_f_avail = r_dv && f_gt(w_reqd, r_avail[r_jd]);
    assign w_f_fit   = r_dv && (w_need_t > r_work[r_jd]);
    assign w_done    = i_cmd.walk_run && r_dv && (CW'(r_jd) == i_nr - CW'(1));
    assign w_commit  = i_cmd.walk_run && (i_cmd.walk_kind == WK_COMMIT) && r_dv;
    assign w_emit_last = (PCW'(r_k) == i_np - PCW'(1));

    always_comb begin
        o_st.item_op2   = (i_op == OP_ALLOC);
        o_st.item_eval  = (i_op == OP_REQ) && i_last;
        o_st.item_bad   = 32'(i_process) >= 32'(i_np);
        o_st.walk_done  = w_done;
        o_st.ex_need    = r_ex_need | w_f_need;
        o_st.ex_avail   = r_ex_avail | w_f_avail;
        o_st.fits       = r_fits & !w_f_fit;
        o_st.fin_cur    = r_fin[r_i];
        o_st.last_proc  = (PCW'(r_i) == i_np - PCW'(1));
        o_st.progress   = r_progress;
        o_st.all_done   = (r_cnt == i_np);
        o_st.clear_done = (r_clr == AW'(DEPTH - 1));
        o_st.out_free   = !r_ov || !i_out_stall;
        o_st.emit_last  = w_emit_last;
    end

    // write port select
    always_comb begin
        w_need_we  = 1'b0;
        w_alloc_we = 1'b0;
        w_wa       = w_item_addr;
        w_need_wd  = '0;
        w_alloc_wd = '0;
        if (i_cmd.clear_step) begin
            w_need_we  = 1'b1;
            w_alloc_we = 1'b1;
            w_wa       = r_clr;
        end else if (i_cmd.accept && w_p_ok && w_r_ok && i_op == OP_MAX) begin
            w_need_we = 1'b1;
            w_need_wd = SW'(w_amt);
        end else if (i_cmd.accept && w_p_ok && w_r_ok && i_op == OP_ALLOC) begin
            w_alloc_we = 1'b1;
            w_alloc_wd = AL'(w_amt);
        end else if (i_cmd.load2 && r_ld_ok) begin
            w_need_we = 1'b1;
            w_wa      = r_ld_addr;
            w_need_wd = f_sub(r_need_rd, r_ld_amt);
        end else if (w_commit) begin
            w_need_we  = 1'b1;
            w_alloc_we = 1'b1;
            w_wa       = w_wb_addr;
            w_need_wd  = f_sub(r_need_rd, w_reqd);
            w_alloc_wd = f_aadd(r_alloc_rd, w_reqd);
        end
    end

    always_ff @(posedge i_clk) begin
        r_need_rd  <= r_need_mem[w_ra];
        r_alloc_rd <= r_alloc_mem[w_ra];
        if (w_need_we) r_need_mem[w_wa] <= w_need_wd;
        if (w_alloc_we) r_alloc_mem[w_wa] <= w_alloc_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_RES; j++) begin
                r_avail[j] <= '0;
                r_req[j]   <= '0;
            end
        end else begin
            if (i_cmd.accept) begin
                case (i_op)
                    OP_TOTAL: if (w_r_ok) r_avail[w_ri] <= SW'(w_amt);
                    OP_ALLOC: if (w_p_ok && w_r_ok) r_avail[w_ri] <= f_sub(r_avail[w_ri], w_amt);
                    OP_REQ:   if (w_r_ok) r_req[w_ri] <= w_amt;
                    default:  ;
                endcase
            end
            if (w_commit) r_avail[r_jd] <= f_sub(r_avail[r_jd], w_reqd);
            if (i_cmd.clear_req) begin
                for (int j = 0; j < MAX_RES; j++) r_req[j] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p       <= PW'(i_process);
            r_ld_addr <= w_item_addr;
            r_ld_amt  <= w_amt;
            r_ld_ok   <= (i_op == OP_ALLOC) && w_p_ok && w_r_ok;
        end
        if (i_cmd.init_work) begin
            for (int j = 0; j < MAX_RES; j++) r_work[j] <= f_sub(r_avail[j], r_req[j]);
        end
        if (i_cmd.walk_run && i_cmd.walk_kind == WK_ADD && r_dv) begin
            r_work[r_jd] <= f_add(r_work[r_jd], w_alloc_t);
        end
        if (i_cmd.mark_fin) r_order[r_cnt[PW-1:0]] <= r_i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_j        <= '0;
            r_jd       <= '0;
            r_dv       <= 1'b0;
            r_ex_need  <= 1'b0;
            r_ex_avail <= 1'b0;
            r_fits     <= 1'b1;
            r_fin      <= '0;
            r_i        <= '0;
            r_cnt      <= '0;
            r_k        <= '0;
            r_progress <= 1'b0;
            r_ov       <= 1'b0;
            r_os       <= ST_GRANT;
            r_osp      <= '0;
            r_of       <= 1'b0;
        end else begin
            if (i_cmd.clear_step) r_clr <= r_clr + AW'(1);
            // element walk, each read issued the cycle before its data is used
            if (!i_cmd.walk_run || w_done) begin
                r_j        <= '0;
                r_dv       <= 1'b0;
                r_ex_need  <= 1'b0;
                r_ex_avail <= 1'b0;
                r_fits     <= 1'b1;
            end else begin
                r_dv       <= w_issue;
                r_jd       <= w_jr;
                if (w_issue) r_j <= r_j + CW'(1);
                r_ex_need  <= o_st.ex_need;
                r_ex_avail <= o_st.ex_avail;
                r_fits     <= o_st.fits;
            end
            if (i_cmd.init_work) begin
                r_fin      <= '0;
                r_i        <= '0;
                r_cnt      <= '0;
                r_progress <= 1'b0;
            end
            if (i_cmd.mark_fin) begin
                r_fin[r_i] <= 1'b1;
                r_cnt      <= r_cnt + PCW'(1);
                r_progress <= 1'b1;
            end
            if (i_cmd.next_proc) r_i <= r_i + PW'(1);
            if (i_cmd.new_pass) begin
                r_i        <= '0;
                r_progress <= 1'b0;
            end
            if (i_cmd.seq_start) r_k <= '0;
            if (i_cmd.emit_seq) begin
                r_ov  <= 1'b1;
                r_os  <= ST_GRANT;
                r_osp <= 3'(r_order[r_k]);
                r_of  <= w_emit_last;
                r_k   <= r_k + PW'(1);
            end else if (i_cmd.emit_stat) begin
                r_ov  <= 1'b1;
                r_os  <= i_cmd.code;
                r_osp <= '0;
                r_of  <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_os;
    assign o_safe_process = r_osp;
    assign o_final_res    = r_of;

endmodule

FILE: hdl/bankers_deadlock_avoidance.sv
// channel   direction  handshake                payload
// input     in         i_in_valid / o_in_stall  op, process, resource, amount, last
// result    out        o_out_valid / i_out_stall status, safe_process, final_res
// config    in         i_cfg_valid / o_cfg_ready index, data
//
// loads and request elements are taken in idle; allocation loads also go through load2
// evaluation: a need/available check walk and a work vector setup, then up to np passes
// of np processes, each with need/allocation memory walks, then a commit walk and the
// result stream
// after reset a clearing pass over all MAX_PROCS*MAX_RES entries holds o_in_stall high
// a waiting result does not block loads; evaluation waits on i_out_stall
module bankers_deadlock_avoidance #(
    parameter int MAX_PROCS = 8,
    parameter int MAX_RES   = 16,
    parameter int UNIT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_process,
    input  logic [3:0]  i_resource,
    input  logic [15:0] i_amount,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [2:0]  o_safe_process,
    output logic        o_final_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);
    import bda_pkg::*;

    localparam int PCW = $clog2(MAX_PROCS + 1);
    localparam int CW  = $clog2(MAX_RES + 1);
    localparam logic [0:0] CFG_PROCS = 1'd0;
    localparam logic [0:0] CFG_RES   = 1'd1;

    logic [3:0]     r_proc_count;
    logic [4:0]     r_res_count;
    logic [PCW-1:0] w_np;
    logic [CW-1:0]  w_nr;
    t_cmd           w_cmd;
    t_stat          w_st;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_count <= 4'd8;
            r_res_count  <= 5'd16;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROCS: r_proc_count <= i_cfg_data[3:0];
                CFG_RES:   r_res_count  <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb begin
        if (r_proc_count == 4'd0) w_np = PCW'(1);
        else if (32'(r_proc_count) > 32'(MAX_PROCS)) w_np = PCW'(MAX_PROCS);
        else w_np = PCW'(r_proc_count);
        if (r_res_count == 5'd0) w_nr = CW'(1);
        else if (32'(r_res_count) > 32'(MAX_RES)) w_nr = CW'(MAX_RES);
        else w_nr = CW'(r_res_count);
    end

    bda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_st       (w_st)
    );

    bda_dp #(
        .MAX_PROCS (MAX_PROCS),
        .MAX_RES   (MAX_RES),
        .UNIT_BITS (UNIT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_st           (w_st),
        .i_op           (i_op),
        .i_process      (i_process),
        .i_resource     (i_resource),
        .i_amount       (i_amount),
        .i_last         (i_last),
        .i_np           (w_np),
        .i_nr           (w_nr),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_safe_process (o_safe_process),
        .o_final_res    (o_final_res)
    );

endmodule

FILE: hdl/bda_checker.sv
`include "bankers_deadlock_avoidance_defines.svh"

module bda_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_status,
    input logic [2:0] o_safe_process,
    input logic       o_final_res
);
    import bda_pkg::*;

    logic w_in_seen;
    assign w_in_seen = i_in_valid && !o_in_stall;

    // stalled result holds
    `BDA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_safe_process) && $stable(o_final_res))

    // refusals are single results with no process
    `BDA_ASSERT_IMP(a_refuse_single, i_clk, i_rst_n, o_out_valid && (o_status != ST_GRANT), o_final_res && (o_safe_process == 3'd0))

    // a safe sequence streams without gaps
    `BDA_ASSERT_NXT(a_seq_stream, i_clk, i_rst_n, o_out_valid && !i_out_stall && (o_status == ST_GRANT) && !o_final_res && !w_in_seen, o_out_valid && (o_status == ST_GRANT))

    // clearing pass follows reset
    `BDA_ASSERT_NXT_ALL(a_reset_clear, i_clk, !i_rst_n, o_in_stall)

endmodule

bind bankers_deadlock_avoidance bda_checker u_bda_checker (.*);

FILE: sim/bankers_deadlock_avoidance_tb.sv
module bankers_deadlock_avoidance_tb;
    import bda_pkg::*;

    localparam int  NPROC    = 8;
    localparam int  NRES     = 16;
    localparam longint SMAX  = (64'sd1 <<< 17) - 1;
    localparam longint SMIN  = -SMAX - 1;
    localparam int  LIMIT    = 3000000;
    localparam int  HOLD_LEN = 1500;
    localparam logic [0:0] REG_PROCS = 1'b0;
    localparam logic [0:0] REG_RES   = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  process;
        logic [3:0]  resource;
        logic [15:0] amount;
        logic        last;
    } alloc_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] safe_process;
        logic       final_res;
    } verdict_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_op = '0;
    logic [2:0]  i_process = '0;
    logic [3:0]  i_resource = '0;
    logic [15:0] i_amount = '0;
    logic        i_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [2:0]  o_safe_process;
    logic        o_final_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [4:0]  i_cfg_data = '0;

    bankers_deadlock_avoidance u_top (.*);

    always #5 i_clk = ~i_clk;

    alloc_item_t pending_items[$];
    verdict_t    verdicts_due[$];
    bit          failed = 0;
    bit          quiet = 0;
    bit          hold_go = 0;
    int          cycles = 0;

    // shadow of the allocator tables
    logic [3:0] sh_procs = 4'd8;
    logic [4:0] sh_res = 5'd16;
    longint     sh_avail[NRES];
    longint     sh_alloc[NPROC*NRES];
    longint     sh_need[NPROC*NRES];
    longint     sh_req[NRES];

    initial begin
        foreach (sh_avail[j]) begin sh_avail[j] = 0; sh_req[j] = 0; end
        foreach (sh_alloc[k]) begin sh_alloc[k] = 0; sh_need[k] = 0; end
    end

    function automatic longint clip(longint v);
        return (v > SMAX) ? SMAX : (v < SMIN) ? SMIN : v;
    endfunction

    function automatic longint clip_alloc(longint v);
        return (v > SMAX) ? SMAX : (v < 0) ? 0 : v;
    endfunction

    function automatic int procs_used();
        return (sh_procs < 1) ? 1 : (sh_procs > NPROC) ? NPROC : int'(sh_procs);
    endfunction

    function automatic int res_used();
        return (sh_res < 1) ? 1 : (sh_res > NRES) ? NRES : int'(sh_res);
    endfunction

    function automatic void grant_or_refuse(alloc_item_t it);
        int np, nr, p, r, k, cnt;
        longint amt;
        logic [2:0] st;
        longint ta[NRES];
        longint tn[NPROC*NRES];
        longint tl[NPROC*NRES];
        longint work[NRES];
        bit done_p[NPROC];
        int order[NPROC];
        bit prog, fits;
        verdict_t v;
        np = procs_used();
        nr = res_used();
        p = it.process;
        r = it.resource;
        amt = it.amount;
        case (it.op)
            OP_TOTAL: begin
                sh_avail[r] = clip(amt);
                return;
            end
            OP_MAX: begin
                sh_need[p*NRES+r] = clip(amt);
                return;
            end
            OP_ALLOC: begin
                k = p*NRES + r;
                sh_alloc[k] = clip_alloc(amt);
                sh_need[k] = clip(sh_need[k] - amt);
                sh_avail[r] = clip(sh_avail[r] - amt);
                return;
            end
            default: ;
        endcase
        sh_req[r] = amt;
        if (!it.last) return;
        st = ST_GRANT;
        if (p >= np) begin
            st = ST_BADPROC;
        end else begin
            for (int j = 0; j < nr; j++)
                if (sh_req[j] > sh_need[p*NRES+j]) st = ST_EXNEED;
            if (st == ST_GRANT)
                for (int j = 0; j < nr; j++)
                    if (sh_req[j] > sh_avail[j]) st = ST_EXAVAIL;
        end
        if (st == ST_GRANT) begin
            ta = sh_avail;
            tn = sh_need;
            tl = sh_alloc;
            for (int j = 0; j < nr; j++) begin
                k = p*NRES + j;
                ta[j] = clip(ta[j] - sh_req[j]);
                tn[k] = clip(tn[k] - sh_req[j]);
                tl[k] = clip_alloc(tl[k] + sh_req[j]);
            end
            for (int j = 0; j < nr; j++) work[j] = ta[j];
            for (int i = 0; i < NPROC; i++) done_p[i] = 0;
            cnt = 0;
            prog = 1;
            while (prog && cnt < np) begin
                prog = 0;
                for (int i = 0; i < np; i++) begin
                    if (!done_p[i]) begin
                        fits = 1;
                        for (int j = 0; j < nr; j++)
                            if (tn[i*NRES+j] > work[j]) fits = 0;
                        if (fits) begin
                            for (int j = 0; j < nr; j++)
                                work[j] = clip(work[j] + tl[i*NRES+j]);
                            done_p[i] = 1;
                            order[cnt] = i;
                            cnt++;
                            prog = 1;
                        end
                    end
                end
            end
            if (cnt == np) begin
                sh_avail = ta;
                sh_need = tn;
                sh_alloc = tl;
                foreach (sh_req[j]) sh_req[j] = 0;
                for (int i = 0; i < np; i++) begin
                    v.status = ST_GRANT;
                    v.safe_process = order[i][2:0];
                    v.final_res = (i + 1 == np);
                    verdicts_due.push_back(v);
                end
                return;
            end
            st = ST_UNSAFE;
        end
        foreach (sh_req[j]) sh_req[j] = 0;
        v.status = st;
        v.safe_process = '0;
        v.final_res = 1'b1;
        verdicts_due.push_back(v);
    endfunction

    // driver
    alloc_item_t cur_item;
    int          in_gap = 0;
    always @(posedge i_clk) begin
        bit nv;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nv = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                grant_or_refuse(cur_item);
                nv = 0;
                in_gap = quiet ? 0 : $urandom_range(0, 10);
            end
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    i_op <= cur_item.op;
                    i_process <= cur_item.process;
                    i_resource <= cur_item.resource;
                    i_amount <= cur_item.amount;
                    i_last <= cur_item.last;
                    nv = 1;
                end
            end
            i_in_valid <= nv;
        end
    end

    // long receiver hold
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_cnt <= HOLD_LEN;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // monitor
    int out_gap = 0;
    always @(posedge i_clk) begin
        verdict_t want;
        bit took;
        took = 0;
        if (o_out_valid && !i_out_stall) begin
            took = 1;
            if (verdicts_due.size() == 0) begin
                $error("result with nothing expected: status %0d", o_status);
                failed = 1;
            end else begin
                want = verdicts_due.pop_front();
                if (o_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_status);
                    failed = 1;
                end
                if (o_safe_process !== want.safe_process) begin
                    $error("safe_process expected %0d actual %0d",
                           want.safe_process, o_safe_process);
                    failed = 1;
                end
                if (o_final_res !== want.final_res) begin
                    $error("final_res expected %0d actual %0d",
                           want.final_res, o_final_res);
                    failed = 1;
                end
            end
        end
        if (took) out_gap = quiet ? 0 : $urandom_range(0, 10);
        if (hold_go || hold_cnt > 0) begin
            i_out_stall <= 1'b1;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("bankers_deadlock_avoidance: mismatch");
            $finish;
        end
    end

    task automatic add_item(logic [1:0] op, int p, int r, int amt, bit last);
        alloc_item_t it;
        it.op = op;
        it.process = p[2:0];
        it.resource = r[3:0];
        it.amount = amt[15:0];
        it.last = last;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || verdicts_due.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [4:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_PROCS) sh_procs = val[3:0];
        else sh_res = val;
        i_cfg_valid <= 1'b0;
    endtask

    // config writes and table loads followed by mostly well-formed requests
    task automatic run_phase(logic [4:0] pc, logic [4:0] rc, int budget, bit full_load);
        int np, nr, n, mx;
        drain();
        write_reg(REG_PROCS, pc);
        write_reg(REG_RES, rc);
        np = procs_used();
        nr = res_used();
        n = 0;
        for (int j = 0; j < nr; j++) begin
            add_item(OP_TOTAL, 0, j, ($urandom_range(0, 9) == 0) ? $urandom
                                                             : $urandom_range(4, 40), 0);
            n++;
        end
        for (int i = 0; i < np; i++)
            for (int j = 0; j < nr; j++)
                if (full_load || $urandom_range(0, 7) == 0) begin
                    mx = $urandom_range(0, 12);
                    add_item(OP_MAX, i, j, mx, 0);
                    add_item(OP_ALLOC, i, j, $urandom_range(0, mx), 0);
                    n += 2;
                end
        while (n < budget) begin
            if ($urandom_range(0, 99) < 85) begin
                int p;
                p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                : $urandom_range(0, np - 1);
                for (int j = 0; j < nr; j++) begin
                    add_item(OP_REQ, p, j,
                             ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0,
                             j == nr - 1);
                    n++;
                end
            end else begin
                add_item(2'($urandom_range(0, 3)), $urandom_range(0, 7),
                         $urandom_range(0, 15), $urandom, 1'($urandom_range(0, 1)));
                n++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases at the reset setting
        add_item(OP_TOTAL, 0, 0, 16'hFFFF, 1);
        add_item(OP_TOTAL, 0, 15, 0, 0);
        add_item(OP_MAX, 7, 15, 16'hFFFF, 0);
        add_item(OP_ALLOC, 0, 0, 16'hFFFF, 0);
        add_item(OP_ALLOC, 0, 0, 16'hFFFF, 0);
        add_item(OP_ALLOC, 3, 5, 0, 1);
        add_item(OP_REQ, 7, 15, 0, 0);
        add_item(OP_REQ, 7, 15, 16'hFFFF, 1);
        add_item(OP_REQ, 0, 0, 1, 1);
        add_item(OP_REQ, 2, 3, 0, 1);
        add_item(OP_MAX, 7, 15, 0, 0);
        add_item(OP_REQ, 1, 0, 0, 1);
        add_item(OP_TOTAL, 0, 7, 16'h5555, 0);
        add_item(OP_MAX, 4, 7, 16'hAAAA, 0);
        add_item(OP_ALLOC, 4, 7, 16'h5555, 0);
        add_item(OP_REQ, 4, 7, 16'h0001, 0);
        add_item(OP_REQ, 4, 3, 16'hAAAA, 0);
        add_item(OP_REQ, 4, 0, 0, 1);
        add_item(OP_REQ, 6, 9, 0, 1);

        quiet = 1;
        run_phase(5'd1, 5'd1, 40, 1);
        quiet = 0;
        run_phase(5'd3, 5'd4, 60, 1);
        run_phase(5'd0, 5'd0, 50, 1);
        run_phase(5'd2, 5'd2, 60, 1);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        run_phase(5'd31, 5'd31, 60, 0);
        run_phase(5'd4, 5'd3, 60, 1);
        run_phase(5'd8, 5'd16, 60, 0);
        quiet = 1;
        run_phase(5'd5, 5'd7, 40, 0);
        quiet = 0;
        drain();
        repeat (50) @(posedge i_clk);
        if (!failed) begin
            $display("bankers_deadlock_avoidance: match");
        end else begin
            $display("bankers_deadlock_avoidance: mismatch");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/bda_pkg.sv
hdl/bda_ctrl.sv
hdl/bda_dp.sv
hdl/bankers_deadlock_avoidance.sv
hdl/bda_checker.sv
sim/bankers_deadlock_avoidance_tb.sv
